>>> sv/hhft_pkg.sv
// hhft_pkg: shared types and constants of the HTTP header field tokeniser.
// Byte codes, token kinds, the token record and the result queue sizing.
// No dependencies; every other file refers to it by scoped name.
package hhft_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 3;

	// Result queue: power-of-two depth so that the pointers wrap by themselves
	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// Characters that steer the parse
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	// Token kinds on the result channel
	localparam logic [KIND_W-1:0] KIND_FIELD     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_VALUE     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BLOCK_END = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} token_t;

endpackage

>>> sv/hhft_byte_if.sv
// hhft_byte_if: valid/ready channel carrying one raw header byte per beat.
// Depends on hhft_pkg for the byte width.
interface hhft_byte_if;
	logic                       valid;
	logic                       ready;
	logic [hhft_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

>>> sv/hhft_token_if.sv
// hhft_token_if: valid/ready channel carrying one tagged token per beat.
// Depends on hhft_pkg for the kind and byte widths.
interface hhft_token_if;
	logic                        valid;
	logic                        ready;
	logic [hhft_pkg::KIND_W-1:0] token_kind;
	logic [hhft_pkg::BYTE_W-1:0] token_byte;
	logic                        last_of_run;

	modport source (output valid, output token_kind, output token_byte,
		output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_byte,
		input last_of_run, output ready);
endinterface

>>> sv/http_header_field_tokenizer.sv
// HTTP header field tokeniser, top level.
// Channels: bytes (sink) takes one raw header byte per beat; tokens (source)
// gives one tagged token per beat: field byte, value byte, header complete,
// block end or error, with last_of_run high on the final token of a byte.
// An accepted byte sits in the input register, is parsed from there into a
// four-entry result queue and shows on tokens once it reaches the queue head.
// Throughput is one byte per cycle. A folded inner space run makes one byte
// give two tokens; the queue soaks these up, and the parse step fires only
// while the queue has room for two entries, which is what sets the rate.
// When the receiver stalls the queue fills, the parse step holds and bytes
// drops ready; nothing is lost or repeated.
// The parse phase only moves on a parse step. After block end every byte is
// swallowed; after an error every byte gives one error token, until reset.
// Reset (arst_n low, asynchronous) returns to line start and empties the
// input register and the queue; no clearing pass is needed.
// Depends on hhft_pkg, hhft_byte_if and hhft_token_if.
module http_header_field_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	hhft_byte_if.sink           bytes,
	hhft_token_if.source        tokens
);

	typedef enum logic [3:0] {
		PH_LINE_START,
		PH_FIELD,
		PH_BEFORE_VALUE,
		PH_VALUE,
		PH_AFTER_VALUE,
		PH_CR_HEADER,
		PH_CR_EMPTY,
		PH_DONE,
		PH_ERROR
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic                         valid_s1;
	logic [hhft_pkg::BYTE_W-1:0]  byte_s1;
	logic [hhft_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [hhft_pkg::CNT_W-1:0]   count_q;
	hhft_pkg::token_t             fifo_q [hhft_pkg::QDEPTH];
	hhft_pkg::token_t             tok0, tok1, head;
	logic [1:0]                   n_tok, push_cnt;
	logic                         adv, pop;

	// Parse step fires when a byte waits and the queue can take two tokens
	assign adv       = valid_s1 && (count_q <= hhft_pkg::CNT_W'(hhft_pkg::QDEPTH - 2));
	assign pop       = tokens.valid && tokens.ready;
	assign push_cnt  = adv ? n_tok : 2'd0;
	assign wr_ptr_nx = wr_ptr_q + hhft_pkg::PTR_W'(1);
	assign bytes.ready = !valid_s1 || adv;

	// Parse one byte against the current phase
	always_comb begin
		phase_d = phase_q;
		n_tok   = 2'd0;
		tok0    = '{kind: hhft_pkg::KIND_FIELD, data: '0, last: 1'b0};
		tok1    = '{kind: hhft_pkg::KIND_VALUE, data: '0, last: 1'b0};
		case (phase_q)
			PH_LINE_START: begin
				if (byte_s1 == hhft_pkg::CH_CR) begin
					phase_d = PH_CR_EMPTY;
				end else if (byte_s1 == hhft_pkg::CH_LF) begin
					phase_d   = PH_DONE;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_BLOCK_END;
				end else if (byte_s1 == hhft_pkg::CH_SPACE) begin
					phase_d   = PH_ERROR;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_ERROR;
				end else if (byte_s1 == hhft_pkg::CH_COLON) begin
					phase_d = PH_BEFORE_VALUE;
				end else begin
					phase_d   = PH_FIELD;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_FIELD;
					tok0.data = byte_s1;
				end
			end
			PH_FIELD: begin
				if (byte_s1 == hhft_pkg::CH_SPACE || byte_s1 == hhft_pkg::CH_CR ||
						byte_s1 == hhft_pkg::CH_LF) begin
					phase_d   = PH_ERROR;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_ERROR;
				end else if (byte_s1 == hhft_pkg::CH_COLON) begin
					phase_d = PH_BEFORE_VALUE;
				end else begin
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_FIELD;
					tok0.data = byte_s1;
				end
			end
			PH_BEFORE_VALUE, PH_VALUE, PH_AFTER_VALUE: begin
				if (byte_s1 == hhft_pkg::CH_SPACE) begin
					// leading spaces dropped; an inner run starts or continues
					if (phase_q == PH_VALUE) begin
						phase_d = PH_AFTER_VALUE;
					end
				end else if (byte_s1 == hhft_pkg::CH_CR || byte_s1 == hhft_pkg::CH_LF) begin
					phase_d   = (byte_s1 == hhft_pkg::CH_CR) ? PH_CR_HEADER : PH_LINE_START;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_HEADER;
				end else if (phase_q == PH_AFTER_VALUE) begin
					// folded space goes out ahead of the byte that ends the run
					phase_d   = PH_VALUE;
					n_tok     = 2'd2;
					tok0.kind = hhft_pkg::KIND_VALUE;
					tok0.data = hhft_pkg::CH_SPACE;
					tok1.kind = hhft_pkg::KIND_VALUE;
					tok1.data = byte_s1;
				end else begin
					phase_d   = PH_VALUE;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_VALUE;
					tok0.data = byte_s1;
				end
			end
			PH_CR_HEADER, PH_CR_EMPTY: begin
				if (byte_s1 == hhft_pkg::CH_LF) begin
					if (phase_q == PH_CR_EMPTY) begin
						phase_d   = PH_DONE;
						n_tok     = 2'd1;
						tok0.kind = hhft_pkg::KIND_BLOCK_END;
					end else begin
						phase_d = PH_LINE_START;
					end
				end else begin
					phase_d   = PH_ERROR;
					n_tok     = 2'd1;
					tok0.kind = hhft_pkg::KIND_ERROR;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d   = PH_ERROR;
				n_tok     = 2'd1;
				tok0.kind = hhft_pkg::KIND_ERROR;
			end
		endcase
		// mark the final token of this byte
		tok0.last = (n_tok == 2'd1);
		tok1.last = (n_tok == 2'd2);
	end

	// Control: phase, input register valid, queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE_START;
			valid_s1 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (adv) begin
				phase_q <= phase_d;
			end
			wr_ptr_q <= wr_ptr_q + hhft_pkg::PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hhft_pkg::PTR_W'(1);
			end
			count_q <= count_q + hhft_pkg::CNT_W'(push_cnt) - hhft_pkg::CNT_W'(pop);
		end
	end

	// Payload: input byte and queue entries
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
		end
		if (push_cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= tok0;
		end
		if (push_cnt == 2'd2) begin
			fifo_q[wr_ptr_nx] <= tok1;
		end
	end

	// Result channel reads the queue head
	assign head               = fifo_q[rd_ptr_q];
	assign tokens.valid       = (count_q != '0);
	assign tokens.token_kind  = head.kind;
	assign tokens.token_byte  = head.data;
	assign tokens.last_of_run = head.last;

`ifndef SYNTH
	// queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hhft_pkg::CNT_W'(hhft_pkg::QDEPTH))
		else $error("result queue over depth");

	// the second token of a folded pair is always queued behind the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && tokens.ready && !tokens.last_of_run) |=> tokens.valid)
		else $error("first token of a pair without its partner");

	// block end and error are terminal until reset
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("left block end phase");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) |=> (phase_q == PH_ERROR))
		else $error("left error phase");
`endif

endmodule
